FILE: rtl/core/msort_pkg.sv
// msort_pkg: shared constants, FSM state type and controller/datapath bundles
// for the merge sort engine. No dependencies.
`timescale 1ns / 1ps

package msort_pkg;

  localparam int BATCH_SIZE = 64;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(BATCH_SIZE);
  localparam int CNT_W      = $clog2(BATCH_SIZE + 1);
  localparam int SUM_W      = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEG_INIT,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_WAIT,
    ST_MERGE,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // input channel open
    logic sort_init;   // first pass, first segment
    logic seg_init;    // set up run bounds for current segment
    logic fetch_a;     // read head of left run
    logic fetch_b;     // read head of right run
    logic merge_step;  // write smaller head, fetch its successor
    logic seg_next;    // advance to next segment pair
    logic pass_next;   // double run width, swap buffers
    logic out_init;    // rewind output index
    logic out_read;    // read sorted word
    logic out_load;    // capture it into the output register
    logic out_next;    // advance output index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_fire;
    logic count_last;
    logic a_avail;
    logic b_avail;
    logic lo_done;
    logic w_done;
    logic out_fire;
    logic out_last;
  } status_t;

endpackage

FILE: rtl/core/msort_ram.sv
// msort_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msort_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/msort_ctrl.sv
// msort_ctrl: sequencer for load, bottom-up merge passes and readout.
// Depends on msort_pkg.
`timescale 1ns / 1ps

module msort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  msort_pkg::status_t status,
  output msort_pkg::cmd_t    cmd
);

  msort_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msort_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msort_pkg::ST_LOAD: begin
        if (status.in_fire && status.count_last) state_next = msort_pkg::ST_SEG_INIT;
      end
      msort_pkg::ST_SEG_INIT: state_next = msort_pkg::ST_FETCH_A;
      msort_pkg::ST_FETCH_A:  state_next = msort_pkg::ST_FETCH_B;
      msort_pkg::ST_FETCH_B:  state_next = msort_pkg::ST_WAIT;
      msort_pkg::ST_WAIT:     state_next = msort_pkg::ST_MERGE;
      msort_pkg::ST_MERGE: begin
        if (status.a_avail || status.b_avail) begin
          state_next = msort_pkg::ST_WAIT;
        end else if (status.lo_done && status.w_done) begin
          state_next = msort_pkg::ST_OUT_RD;
        end else begin
          state_next = msort_pkg::ST_SEG_INIT;
        end
      end
      msort_pkg::ST_OUT_RD: state_next = msort_pkg::ST_OUT_LD;
      msort_pkg::ST_OUT_LD: state_next = msort_pkg::ST_OUT_HOLD;
      msort_pkg::ST_OUT_HOLD: begin
        if (status.out_fire) begin
          state_next = status.out_last ? msort_pkg::ST_LOAD : msort_pkg::ST_OUT_RD;
        end
      end
      default: state_next = msort_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      msort_pkg::ST_LOAD: begin
        cmd.load      = 1'b1;
        cmd.sort_init = status.in_fire && status.count_last;
      end
      msort_pkg::ST_SEG_INIT: cmd.seg_init = 1'b1;
      msort_pkg::ST_FETCH_A:  cmd.fetch_a  = 1'b1;
      msort_pkg::ST_FETCH_B:  cmd.fetch_b  = 1'b1;
      msort_pkg::ST_WAIT:     ;
      msort_pkg::ST_MERGE: begin
        if (status.a_avail || status.b_avail) begin
          cmd.merge_step = 1'b1;
        end else if (!status.lo_done) begin
          cmd.seg_next = 1'b1;
        end else begin
          cmd.pass_next = 1'b1;
          cmd.out_init  = status.w_done;
        end
      end
      msort_pkg::ST_OUT_RD: cmd.out_read = 1'b1;
      msort_pkg::ST_OUT_LD: cmd.out_load = 1'b1;
      msort_pkg::ST_OUT_HOLD: cmd.out_next = status.out_fire && !status.out_last;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/msort_dp.sv
// msort_dp: ping-pong buffers, run indexes, head registers and output register.
// Depends on msort_pkg and msort_ram.
`timescale 1ns / 1ps

module msort_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  msort_pkg::cmd_t                       cmd,
  output msort_pkg::status_t                    status,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [msort_pkg::DATA_WIDTH-1:0] sample_value,
  output logic                                  sorted_valid,
  input  logic                                  sorted_ready,
  output logic signed [msort_pkg::DATA_WIDTH-1:0] sorted_value,
  output logic                                  is_final
);

  localparam int DW = msort_pkg::DATA_WIDTH;
  localparam int AW = msort_pkg::ADDR_W;
  localparam int CW = msort_pkg::CNT_W;
  localparam int SW = msort_pkg::SUM_W;

  logic [CW-1:0] count;
  logic [CW-1:0] w;
  logic [CW-1:0] lo;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] a_idx;
  logic [CW-1:0] b_idx;
  logic [CW-1:0] k;
  logic          sel;      // 0: store is source, 1: buffer is source
  logic          pend_a;
  logic          pend_b;
  logic          out_valid;
  logic signed [DW-1:0] head_a;
  logic signed [DW-1:0] head_b;

  logic          in_fire;
  logic          out_fire;
  logic          take_a;
  logic [SW-1:0] sum_mid;
  logic [SW-1:0] sum_hi;
  logic [SW-1:0] sum_lo_next;
  logic [SW-1:0] sum_w2;
  logic [CW-1:0] mid_next;
  logic [CW-1:0] hi_next;
  logic [CW-1:0] a_inc;
  logic [CW-1:0] b_inc;
  logic [CW-1:0] rd_idx;
  logic [DW-1:0] win_val;
  logic [DW-1:0] rdata0;
  logic [DW-1:0] rdata1;
  logic [DW-1:0] rdata;
  logic          we0;
  logic          we1;
  logic [AW-1:0] waddr0;
  logic [DW-1:0] wdata0;

  assign in_fire      = sample_valid && cmd.load;
  assign sample_ready = cmd.load;
  assign out_fire     = out_valid && sorted_ready;
  assign sorted_valid = out_valid;

  // run bounds, clamped to the batch
  assign sum_mid     = SW'(lo) + SW'(w);
  assign sum_hi      = sum_mid + SW'(w);
  assign sum_lo_next = sum_hi;
  assign sum_w2      = {w, 1'b0};
  assign mid_next    = (sum_mid > SW'(msort_pkg::BATCH_SIZE)) ?
                       CW'(msort_pkg::BATCH_SIZE) : sum_mid[CW-1:0];
  assign hi_next     = (sum_hi > SW'(msort_pkg::BATCH_SIZE)) ?
                       CW'(msort_pkg::BATCH_SIZE) : sum_hi[CW-1:0];

  assign status.in_fire    = in_fire;
  assign status.count_last = (count == CW'(msort_pkg::BATCH_SIZE - 1));
  assign status.a_avail    = (a_idx < mid);
  assign status.b_avail    = (b_idx < hi);
  assign status.lo_done    = (sum_lo_next >= SW'(msort_pkg::BATCH_SIZE));
  assign status.w_done     = (sum_w2 >= SW'(msort_pkg::BATCH_SIZE));
  assign status.out_fire   = out_fire;
  assign status.out_last   = (k == CW'(msort_pkg::BATCH_SIZE - 1));

  // ties go to the right run
  assign take_a  = status.a_avail && (!status.b_avail || (head_a < head_b));
  assign win_val = take_a ? head_a : head_b;
  assign a_inc   = a_idx + CW'(1);
  assign b_inc   = b_idx + CW'(1);

  always_comb begin
    rd_idx = k;
    if (cmd.fetch_a) begin
      rd_idx = a_idx;
    end else if (cmd.fetch_b) begin
      rd_idx = b_idx;
    end else if (cmd.merge_step) begin
      rd_idx = take_a ? a_inc : b_inc;
    end
  end

  assign we0    = in_fire || (cmd.merge_step && sel);
  assign we1    = cmd.merge_step && !sel;
  assign waddr0 = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign wdata0 = cmd.load ? sample_value : win_val;
  assign rdata  = sel ? rdata1 : rdata0;

  msort_ram #(.WIDTH(DW), .DEPTH(msort_pkg::BATCH_SIZE)) u_store (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata0)
  );

  msort_ram #(.WIDTH(DW), .DEPTH(msort_pkg::BATCH_SIZE)) u_buffer (
    .clk   (clk),
    .we    (we1),
    .waddr (k[AW-1:0]),
    .wdata (win_val),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata1)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count <= status.count_last ? '0 : count + CW'(1);
      end
      pend_a <= cmd.fetch_a || (cmd.merge_step && take_a);
      pend_b <= cmd.fetch_b || (cmd.merge_step && !take_a);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // indexes and data
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      lo  <= '0;
      w   <= CW'(1);
      sel <= 1'b0;
    end
    if (cmd.seg_init) begin
      mid   <= mid_next;
      hi    <= hi_next;
      a_idx <= lo;
      b_idx <= mid_next;
      k     <= lo;
    end
    if (cmd.merge_step) begin
      k <= k + CW'(1);
      if (take_a) begin
        a_idx <= a_inc;
      end else begin
        b_idx <= b_inc;
      end
    end
    if (cmd.seg_next) begin
      lo <= sum_lo_next[CW-1:0];
    end
    if (cmd.pass_next) begin
      lo  <= '0;
      w   <= sum_w2[CW-1:0];
      sel <= !sel;
    end
    if (cmd.out_init) begin
      k <= '0;
    end
    if (cmd.out_next) begin
      k <= k + CW'(1);
    end
    if (pend_a) begin
      head_a <= rdata;
    end
    if (pend_b) begin
      head_b <= rdata;
    end
    if (cmd.out_load) begin
      sorted_value <= rdata;
      is_final     <= status.out_last;
    end
  end

endmodule

FILE: rtl/core/merge_sort_engine_top.sv
// merge_sort_engine_top: top level of the batch merge sorter.
// Depends on msort_pkg, msort_ctrl, msort_dp (and msort_ram through msort_dp).
`timescale 1ns / 1ps

// Usage
// - Input channel (sample_valid/sample_ready/sample_value): one signed word per
//   transfer. sample_ready is high only while the engine collects a batch.
// - After the 64th word the engine sorts the batch ascending (bottom-up merge
//   sort through two ping-pong RAMs) and then streams the 64 words out on the
//   output channel (sorted_valid/sorted_ready/sorted_value/is_final), with
//   is_final high on the last one. Input stays closed until it is taken.
// - Loading: one word per cycle while sample_valid is high.
// - Sorting: log2(N) passes; each word of a pass takes a compare/write step and
//   then a wait while the single RAM read port refetches the consumed run head;
//   each segment pair adds bound setup, head fetch and the closing check.
// - Readout: each word is read, registered, then handed over; a stall simply
//   holds the output register and its word.
// - Reset (rst, synchronous): the engine returns to collecting, with an empty
//   batch and no pending output. RAM contents are not cleared; every entry is
//   written before it is read.

module merge_sort_engine_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    sample_valid,
  output logic                                    sample_ready,
  input  logic signed [msort_pkg::DATA_WIDTH-1:0] sample_value,
  output logic                                    sorted_valid,
  input  logic                                    sorted_ready,
  output logic signed [msort_pkg::DATA_WIDTH-1:0] sorted_value,
  output logic                                    is_final
);

  msort_pkg::cmd_t    cmd;
  msort_pkg::status_t status;

  msort_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  msort_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .sorted_valid (sorted_valid),
    .sorted_ready (sorted_ready),
    .sorted_value (sorted_value),
    .is_final     (is_final)
  );

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for merge_sort_engine_top. Batches of signed words are
// driven in, sorted in a local model and compared word by word with the output stream.
// Depends on msort_pkg and the merge_sort_engine_top RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef logic signed [msort_pkg::DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  last;
  } sorted_word_t;

  // Content shape of one generated batch (or of an 8-word chunk in the mixed batch).
  typedef enum int {
    FILL_RANDOM,
    FILL_DESCEND,
    FILL_NARROW,
    FILL_ASCEND,
    FILL_CONST,
    FILL_MIXED
  } fill_kind_t;

  localparam int NUM_BATCHES = 4;
  localparam int TOTAL_WORDS = NUM_BATCHES * msort_pkg::BATCH_SIZE;
  localparam int DRAIN_CYCLES = 1500;  // longer than one full sort pass set

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // DUT ports; every input has a known value from time zero
  logic  sample_valid = 1'b0;
  logic  sample_ready;
  word_t sample_value = '0;
  logic  sorted_valid;
  logic  sorted_ready = 1'b0;
  word_t sorted_value;
  logic  is_final;

  merge_sort_engine_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .sorted_valid (sorted_valid),
    .sorted_ready (sorted_ready),
    .sorted_value (sorted_value),
    .is_final     (is_final)
  );

  // Bench state
  word_t        pending_words[$];   // words not yet offered to the DUT
  sorted_word_t sorted_expect[$];   // predicted output stream, oldest first
  word_t        batch_buf[msort_pkg::BATCH_SIZE];
  int           batch_fill = 0;
  int           n_accepted = 0;
  int           n_words_seen = 0;
  int           mismatch_count = 0;

  // Idle percentage for the current phase; phases rotate once per batch:
  // none, sender only, receiver only, both at a lighter rate.
  function automatic int idle_pct(input int count, input bit sender);
    int phase;
    begin
      phase = (count / msort_pkg::BATCH_SIZE) % 4;
      case (phase)
        1: idle_pct = sender ? 47 : 0;
        2: idle_pct = sender ? 0 : 47;
        3: idle_pct = 18;
        default: idle_pct = 0;
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what);
    begin
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
    end
  endtask

  // Local model: collect the batch; on the last word run a bottom-up merge sort
  // (right run wins ties) and queue the whole sorted stream.
  task automatic take_sample(input word_t v);
    word_t        src[msort_pkg::BATCH_SIZE];
    word_t        dst[msort_pkg::BATCH_SIZE];
    int           run_len, lo, mid, hi, a, b, k;
    sorted_word_t w;
    begin
      batch_buf[batch_fill] = v;
      batch_fill++;
      if (batch_fill == msort_pkg::BATCH_SIZE) begin
        src = batch_buf;
        for (run_len = 1; run_len < msort_pkg::BATCH_SIZE; run_len *= 2) begin
          dst = src;  // an unpaired tail run passes through unchanged
          for (lo = 0; lo + run_len < msort_pkg::BATCH_SIZE; lo += 2 * run_len) begin
            mid = lo + run_len;
            hi = (mid + run_len > msort_pkg::BATCH_SIZE) ? msort_pkg::BATCH_SIZE :
                 mid + run_len;
            a = lo;
            b = mid;
            for (k = lo; k < hi; k++) begin
              if (b >= hi || (a < mid && src[a] < src[b])) begin
                dst[k] = src[a];
                a++;
              end else begin
                dst[k] = src[b];
                b++;
              end
            end
          end
          src = dst;
        end
        for (k = 0; k < msort_pkg::BATCH_SIZE; k++) begin
          w.value = src[k];
          w.last  = (k == msort_pkg::BATCH_SIZE - 1);
          sorted_expect.push_back(w);
        end
        batch_fill = 0;
      end
    end
  endtask

  // Word generator for the random batches.
  function automatic word_t gen_word(input fill_kind_t kind, input int idx, input int base);
    int v;
    begin
      case (kind)
        FILL_DESCEND: v = 32767 - idx * 1000 - $urandom_range(0, 999);
        FILL_ASCEND:  v = -32768 + idx * 1000 + $urandom_range(0, 999);
        FILL_NARROW:  v = base + $urandom_range(0, 3);  // heavy ties, may wrap
        FILL_CONST:   v = base;
        default:      v = $urandom_range(0, 65535);
      endcase
      gen_word = word_t'(v);
    end
  endfunction

  // Driver: offers the next pending word; valid is held with its word until taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        take_sample(sample_value);
        n_accepted++;
      end
      if (!sample_valid || sample_ready) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= idle_pct(n_accepted, 1'b1)) begin
          sample_valid <= 1'b1;
          sample_value <= pending_words.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output word against the oldest prediction.
  always @(posedge clk) begin
    sorted_word_t exp_w;
    if (rst) begin
      sorted_ready <= 1'b0;
    end else begin
      if (sorted_valid && sorted_ready) begin
        if (sorted_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d final %0b", sorted_value, is_final));
        end else begin
          exp_w = sorted_expect.pop_front();
          if (sorted_value !== exp_w.value)
            report_mismatch($sformatf("word %0d: value %0d, want %0d",
                                      n_words_seen, sorted_value, exp_w.value));
          if (is_final !== exp_w.last)
            report_mismatch($sformatf("word %0d: is_final %0b, want %0b",
                                      n_words_seen, is_final, exp_w.last));
        end
        n_words_seen++;
      end
      sorted_ready <= ($urandom_range(0, 99) >= idle_pct(n_words_seen, 1'b0));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    word_t      directed[$];
    fill_kind_t kinds[NUM_BATCHES];
    fill_kind_t chunk_kind;
    int         base, i, b;

    // Batch 0: field extremes and bit patterns first, the rest random.
    directed = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                 16'sh8001, 16'sh7FFE, 16'sh5555, 16'shAAAA, 16'sh8000,
                 16'sh7FFF, 16'sh00FF, 16'shFF00, 16'sh0000, 16'shFFFE,
                 16'sh4000, 16'shC000, 16'sh3FFF, 16'shBFFF, 16'sh0001};
    foreach (directed[j]) pending_words.push_back(directed[j]);
    for (i = directed.size(); i < msort_pkg::BATCH_SIZE; i++)
      pending_words.push_back(gen_word(FILL_RANDOM, i, 0));

    // Remaining batches stress ordering: reversed input, many ties,
    // and chunks of mixed shapes.
    kinds = '{FILL_RANDOM, FILL_DESCEND, FILL_NARROW, FILL_MIXED};
    for (b = 1; b < NUM_BATCHES; b++) begin
      base = $urandom_range(0, 65535);
      chunk_kind = kinds[b];
      for (i = 0; i < msort_pkg::BATCH_SIZE; i++) begin
        if (kinds[b] == FILL_MIXED && i % 8 == 0) begin
          chunk_kind = fill_kind_t'($urandom_range(FILL_RANDOM, FILL_CONST));
          base = $urandom_range(0, 65535);
        end
        pending_words.push_back(gen_word(chunk_kind, i, base));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < TOTAL_WORDS || sorted_expect.size() != 0) @(posedge clk);
    // Let any stray output show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && sorted_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: fails a run that has not finished by the timeout below.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/msort_pkg.sv
rtl/core/msort_ram.sv
rtl/core/msort_ctrl.sv
rtl/core/msort_dp.sv
rtl/core/merge_sort_engine_top.sv
verif/tb_top.sv
